### rtl/rbc_pkg.sv
// Shared types and constants for the red blob centroid block.
package rbc_pkg;

	localparam int CHAN_W      = 8;
	localparam int COORD_W     = 11;
	localparam int CNT_W       = 23;
	localparam int SUM_W       = 34;
	localparam int IDX_W       = 3;
	localparam int CFG_W       = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_CR_THRESHOLD  = 3'd0;
	localparam logic [IDX_W-1:0] REG_REGION_LEFT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_REGION_TOP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_REGION_RIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_REGION_BOTTOM = 3'd4;

	localparam logic [CHAN_W-1:0]  THRESHOLD_RESET = 8'd150;
	localparam logic [COORD_W-1:0] REGION_LO_RESET = 11'd0;
	localparam logic [COORD_W-1:0] REGION_HI_RESET = 11'd2047;

	// 14-bit fixed point luma and chroma red coefficients
	localparam logic [13:0] Y_COEF_B  = 14'd1868;
	localparam logic [13:0] Y_COEF_G  = 14'd9617;
	localparam logic [13:0] Y_COEF_R  = 14'd4899;
	localparam logic [21:0] Y_ROUND   = 22'd8192;
	localparam logic signed [24:0] CR_COEF   = 25'sd11682;
	localparam logic signed [24:0] CR_OFFSET = 25'sd2105344;

	typedef struct packed {
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  red;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic               marked;
		logic               centroid_valid;
		logic               found;
		logic [COORD_W-1:0] center_col;
		logic [COORD_W-1:0] center_row;
		logic [CNT_W-1:0]   marked_count;
	} result_t;

	// one classified pixel on its way to the back part
	typedef struct packed {
		logic             marked;
		logic             last;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] col_sum;
		logic [SUM_W-1:0] row_sum;
	} tally_t;

endpackage

### rtl/rbc_front.sv
// Front part: region gate, chroma red threshold and running sums.
module rbc_front
	import rbc_pkg::*;
#(
	parameter int COORD_W_EFF = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pixel_t             pixel,
	input  logic               cfg_valid,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               q_push,
	input  logic               q_full,
	output tally_t             q_data
);

	localparam logic [COORD_W-1:0] MASK = COORD_W'((1 << COORD_W_EFF) - 1);

	logic [CHAN_W-1:0]  thr_q;
	logic [COORD_W-1:0] left_q, top_q, right_q, bottom_q;

	logic [CNT_W-1:0] hit_q;
	logic [SUM_W-1:0] col_sum_q, row_sum_q;

	logic               vld_s1;
	logic [CHAN_W-1:0]  red_s1, luma_s1;
	logic [COORD_W-1:0] col_s1, row_s1;
	logic               inside_s1, last_s1;

	logic [COORD_W-1:0] col_m, row_m;
	logic               inside_c;
	logic [21:0]        luma_acc;
	logic               accept;

	logic signed [9:0]  diff_c;
	logic signed [24:0] cr_full;
	logic [9:0]         cr_wide;
	logic [CHAN_W-1:0]  cr_c;
	logic               mark_c, inc_c;
	logic [CNT_W-1:0]   hit_n;
	logic [SUM_W-1:0]   col_sum_n, row_sum_n;

	assign col_m = pixel.col & MASK;
	assign row_m = pixel.row & MASK;
	assign inside_c = (col_m >= (left_q & MASK)) && (col_m <= (right_q & MASK)) &&
		(row_m >= (top_q & MASK)) && (row_m <= (bottom_q & MASK));
	assign luma_acc = 22'(pixel.blue * Y_COEF_B) + 22'(pixel.green * Y_COEF_G) +
		22'(pixel.red * Y_COEF_R) + Y_ROUND;

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;
	assign q_push = vld_s1 && !q_full;

	// chroma red from the registered luma
	assign diff_c  = $signed({2'b00, red_s1}) - $signed({2'b00, luma_s1});
	assign cr_full = 25'(diff_c) * CR_COEF + CR_OFFSET;
	assign cr_wide = cr_full[23:14];
	always_comb begin
		if (cr_full[24])
			cr_c = '0;
		else if (cr_wide > 10'd255)
			cr_c = '1;
		else
			cr_c = cr_wide[CHAN_W-1:0];
	end

	assign mark_c    = inside_s1 && (cr_c > thr_q);
	assign inc_c     = mark_c && (hit_q != CNT_MAX);
	assign hit_n     = inc_c ? hit_q + 1'b1 : hit_q;
	assign col_sum_n = inc_c ? col_sum_q + SUM_W'(col_s1) : col_sum_q;
	assign row_sum_n = inc_c ? row_sum_q + SUM_W'(row_s1) : row_sum_q;

	assign q_data.marked  = mark_c;
	assign q_data.last    = last_s1;
	assign q_data.count   = hit_n;
	assign q_data.col_sum = col_sum_n;
	assign q_data.row_sum = row_sum_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RESET;
			left_q   <= REGION_LO_RESET;
			top_q    <= REGION_LO_RESET;
			right_q  <= REGION_HI_RESET;
			bottom_q <= REGION_HI_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CR_THRESHOLD:  thr_q    <= cfg_data[CHAN_W-1:0];
				REG_REGION_LEFT:   left_q   <= cfg_data;
				REG_REGION_TOP:    top_q    <= cfg_data;
				REG_REGION_RIGHT:  right_q  <= cfg_data;
				REG_REGION_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			hit_q     <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else begin
			if (accept)
				vld_s1 <= 1'b1;
			else if (q_push)
				vld_s1 <= 1'b0;
			if (q_push) begin
				// sums restart after the frame's last pixel
				hit_q     <= last_s1 ? '0 : hit_n;
				col_sum_q <= last_s1 ? '0 : col_sum_n;
				row_sum_q <= last_s1 ? '0 : row_sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1    <= pixel.red;
			luma_s1   <= luma_acc[21:14];
			col_s1    <= col_m;
			row_s1    <= row_m;
			inside_s1 <= inside_c;
			last_s1   <= pixel.frame_end;
		end
	end

endmodule

### rtl/rbc_queue.sv
// Short queue of classified pixels between the front and back parts.
module rbc_queue
	import rbc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  tally_t data_in,
	output logic   full,
	input  logic   pop,
	output tally_t data_out,
	output logic   empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	tally_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign full     = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign data_out = slot_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= data_in;
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("front pushed into a full queue");
`endif

endmodule

### rtl/rbc_back.sv
// Back part: per-frame centroid divider and the result register.
module rbc_back
	import rbc_pkg::*;
#(
	parameter int COORD_W_EFF = 11
) (
	input  logic    clk,
	input  logic    arst_n,
	input  tally_t  head,
	input  logic    q_empty,
	output logic    q_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	localparam int STEP_W = $clog2(COORD_W_EFF + 1);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

	state_t                 state_q;
	result_t                out_q;
	logic                   out_vld_q;
	logic [CNT_W-1:0]       div_q, cnt_q;
	logic [CNT_W-1:0]       crem_q, rrem_q;
	logic [COORD_W_EFF-1:0] cq_q, rq_q;
	logic [STEP_W-1:0]      step_q;
	logic                   mk_q;

	logic          slot_free, head_div, load_c;
	logic [CNT_W:0] ctrial, rtrial, cdiff, rdiff;
	logic          cge, rge;

	assign result    = out_q;
	assign empty     = !out_vld_q;
	assign slot_free = !out_vld_q || pop;
	assign head_div  = head.last && (head.count != '0);
	assign q_pop     = (state_q == S_IDLE) && !q_empty && (head_div || slot_free);
	// result register takes a new request from the queue head or the divider
	assign load_c    = ((state_q == S_IDLE) && !q_empty && !head_div && slot_free) ||
		((state_q == S_DONE) && slot_free);

	// restoring division, one quotient bit per cycle for column and row
	assign ctrial = {crem_q, cq_q[COORD_W_EFF-1]};
	assign rtrial = {rrem_q, rq_q[COORD_W_EFF-1]};
	assign cdiff  = ctrial - {1'b0, div_q};
	assign rdiff  = rtrial - {1'b0, div_q};
	assign cge    = ctrial >= {1'b0, div_q};
	assign rge    = rtrial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			step_q    <= '0;
			out_q     <= '0;
			div_q     <= '0;
			cnt_q     <= '0;
			mk_q      <= 1'b0;
			crem_q    <= '0;
			rrem_q    <= '0;
			cq_q      <= '0;
			rq_q      <= '0;
		end else begin
			if (load_c)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (head_div) begin
							div_q  <= head.count;
							cnt_q  <= head.count;
							mk_q   <= head.marked;
							// quotient fits the coordinate width, so the upper part
							// of each sum is already below the divisor
							crem_q <= head.col_sum[COORD_W_EFF+CNT_W-1:COORD_W_EFF];
							rrem_q <= head.row_sum[COORD_W_EFF+CNT_W-1:COORD_W_EFF];
							cq_q   <= head.col_sum[COORD_W_EFF-1:0];
							rq_q   <= head.row_sum[COORD_W_EFF-1:0];
							step_q <= '0;
							state_q <= S_DIV;
						end else if (slot_free) begin
							out_q.marked         <= head.marked;
							out_q.centroid_valid <= head.last;
							out_q.found          <= 1'b0;
							out_q.center_col     <= '0;
							out_q.center_row     <= '0;
							out_q.marked_count   <= head.count;
						end
					end
				end
				S_DIV: begin
					crem_q <= cge ? cdiff[CNT_W-1:0] : ctrial[CNT_W-1:0];
					rrem_q <= rge ? rdiff[CNT_W-1:0] : rtrial[CNT_W-1:0];
					cq_q   <= {cq_q[COORD_W_EFF-2:0], cge};
					rq_q   <= {rq_q[COORD_W_EFF-2:0], rge};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(COORD_W_EFF - 1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						out_q.marked         <= mk_q;
						out_q.centroid_valid <= 1'b1;
						out_q.found          <= 1'b1;
						out_q.center_col     <= COORD_W'(cq_q);
						out_q.center_row     <= COORD_W'(rq_q);
						out_q.marked_count   <= cnt_q;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_q != '0)
		else $error("centroid division by zero count");
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && slot_free) |=> out_vld_q && out_q.found)
		else $error("centroid result not loaded");
`endif

endmodule

### rtl/red_blob_centroid.sv
// Top level of the red blob centroid block.
// Pixels enter through a queue-like port: an item goes in when push is high
// and full is low. Results leave the same way: the oldest result sits on
// result while empty is low and is taken when pop is high.
// Every pixel gives one result: its mark and the running marked count. The
// frame_end pixel also carries the truncated centroid and found.
// Ordinary pixels pass the front stage register, the queue and the result
// register. A frame end with marked pixels is also held in the back part
// by a one-bit-per-cycle divider for the means (COORD_BITS capped at 11).
// Front and back each pass one pixel per cycle between frame ends while the
// queue has room and the receiver keeps popping; every dividing frame end
// holds the back, which the 4-entry queue only partly hides from the input.
// When the receiver stops popping, the result register and the queue fill and
// full rises; nothing is dropped.
// Registers are written over cfg_valid/cfg_index/cfg_data, always ready;
// write only while idle. Reset clears sums, queue and result register and
// loads the threshold (150) and a full-frame region.
module red_blob_centroid
	import rbc_pkg::*;
#(
	parameter int COORD_BITS = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  pixel_t           pixel,
	output logic             empty,
	input  logic             pop,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

	tally_t front_data, head;
	logic   front_push, q_full, q_empty, q_pop;

	assign cfg_ready = 1'b1;

	rbc_front #(
		.COORD_W_EFF(CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (front_push),
		.q_full    (q_full),
		.q_data    (front_data)
	);

	rbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.data_in  (front_data),
		.full     (q_full),
		.pop      (q_pop),
		.data_out (head),
		.empty    (q_empty)
	);

	rbc_back #(
		.COORD_W_EFF(CW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
